>>> rtl/amzmp_pkg.sv
package amzmp_pkg;

	localparam int ACCEL_W   = 16;
	localparam int COM_W     = 24;
	localparam int ZMP_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_COM_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COM_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COM_Z = 2'd2;

	// 103.6602 cm in Q.8
	localparam logic signed [COM_W-1:0] COM_Z_RESET = 24'sd26537;

	typedef struct packed {
		logic signed [ACCEL_W-1:0] accel_x;
		logic signed [ACCEL_W-1:0] accel_y;
		logic signed [ACCEL_W-1:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic signed [ZMP_W-1:0] zmp_x;
		logic signed [ZMP_W-1:0] zmp_y;
		logic                    zero_divisor;
	} result_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic mul_x;
		logic mul_y;
		logic load;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic sum_z_zero;
		logic out_busy;
	} stat_t;

endpackage

>>> rtl/amzmp_if.sv
interface amzmp_sample_if;
	logic                 valid;
	logic                 ready;
	amzmp_pkg::sample_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface amzmp_result_if;
	logic                 valid;
	logic                 ready;
	amzmp_pkg::result_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/amzmp_div.sv
// Restoring divider, one quotient bit per step. Divisor must hold during steps.
module amzmp_div #(
	parameter int DVD_W = 44,
	parameter int DVS_W = 21
) (
	input  logic             clk,
	input  logic             start,
	input  logic             step,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient
);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   part;
	logic [DVS_W:0]   diff;

	assign part = {rem_q, quo_q[DVD_W-1]};
	assign diff = part - {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			if (!diff[DVS_W]) begin
				rem_q <= diff[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= part[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;

endmodule

>>> rtl/amzmp_dp.sv
module amzmp_dp #(
	parameter int WINDOW_LEN = 30
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  amzmp_pkg::cmd_t                     cmd,
	output amzmp_pkg::stat_t                    stat,
	input  logic                                cfg_we,
	input  logic [amzmp_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [amzmp_pkg::CFG_W-1:0]         cfg_data,
	input  amzmp_pkg::sample_t                  in_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output amzmp_pkg::result_t                  out_data
);

	localparam int ADDR_W = $clog2(WINDOW_LEN);
	localparam int SUM_W  = amzmp_pkg::ACCEL_W + $clog2(WINDOW_LEN);
	localparam int PROD_W = amzmp_pkg::COM_W + SUM_W;
	localparam int MAG_W  = PROD_W - 1;
	localparam int RES_W  = MAG_W + 2;
	localparam int ZW     = amzmp_pkg::ZMP_W;

	logic signed [amzmp_pkg::COM_W-1:0] com_x_q, com_y_q, com_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			com_x_q <= '0;
			com_y_q <= '0;
			com_z_q <= amzmp_pkg::COM_Z_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				amzmp_pkg::CFG_COM_X: com_x_q <= cfg_data;
				amzmp_pkg::CFG_COM_Y: com_y_q <= cfg_data;
				amzmp_pkg::CFG_COM_Z: com_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample window: one read at accept, one write at update
	amzmp_pkg::sample_t mem [WINDOW_LEN];
	amzmp_pkg::sample_t rd_q;
	amzmp_pkg::sample_t samp_s1;
	amzmp_pkg::sample_t old_smp;
	logic [WINDOW_LEN-1:0] valid_q;
	logic [ADDR_W-1:0]     slot_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_q    <= mem[slot_q];
			samp_s1 <= in_data;
		end
		if (cmd.update)
			mem[slot_q] <= samp_s1;
	end

	// never-written entries read as zero
	assign old_smp = valid_q[slot_q] ? rd_q : '0;

	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			slot_q  <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
		end else if (cmd.update) begin
			valid_q[slot_q] <= 1'b1;
			slot_q  <= (slot_q == ADDR_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
			sum_x_q <= sum_x_q + SUM_W'(samp_s1.accel_x) - SUM_W'(old_smp.accel_x);
			sum_y_q <= sum_y_q + SUM_W'(samp_s1.accel_y) - SUM_W'(old_smp.accel_y);
			sum_z_q <= sum_z_q + SUM_W'(samp_s1.accel_z) - SUM_W'(old_smp.accel_z);
		end
	end

	// one shared multiplier: x product first, then y
	logic signed [SUM_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_q, prod_x_q;

	assign mul_b = cmd.mul_y ? sum_y_q : sum_x_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_x || cmd.mul_y)
			prod_q <= com_z_q * mul_b;
		if (cmd.mul_y)
			prod_x_q <= prod_q;
	end

	logic [PROD_W-1:0] abs_x, abs_y;
	logic [SUM_W-1:0]  abs_z;
	logic [SUM_W-1:0]  dvs_q;
	logic              neg_x_q, neg_y_q;
	logic [MAG_W-1:0]  quo_x, quo_y;

	assign abs_x = prod_x_q[PROD_W-1] ? -prod_x_q : prod_x_q;
	assign abs_y = prod_q[PROD_W-1] ? -prod_q : prod_q;
	assign abs_z = sum_z_q[SUM_W-1] ? -sum_z_q : sum_z_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvs_q   <= abs_z;
			neg_x_q <= prod_x_q[PROD_W-1] ^ sum_z_q[SUM_W-1];
			neg_y_q <= prod_q[PROD_W-1] ^ sum_z_q[SUM_W-1];
		end
	end

	amzmp_div #(.DVD_W(MAG_W), .DVS_W(SUM_W)) u_div_x (
		.clk      (clk),
		.start    (cmd.load),
		.step     (cmd.div_step),
		.dividend (abs_x[MAG_W-1:0]),
		.divisor  (dvs_q),
		.quotient (quo_x)
	);

	amzmp_div #(.DVD_W(MAG_W), .DVS_W(SUM_W)) u_div_y (
		.clk      (clk),
		.start    (cmd.load),
		.step     (cmd.div_step),
		.dividend (abs_y[MAG_W-1:0]),
		.divisor  (dvs_q),
		.quotient (quo_y)
	);

	// com_x - q and com_y + q with the quotient sign folded into add/sub
	logic signed [RES_W-1:0] cx, cy, qx, qy, res_x, res_y;

	assign cx    = RES_W'(com_x_q);
	assign cy    = RES_W'(com_y_q);
	assign qx    = $signed({2'b00, quo_x});
	assign qy    = $signed({2'b00, quo_y});
	assign res_x = neg_x_q ? cx + qx : cx - qx;
	assign res_y = neg_y_q ? cy - qy : cy + qy;

	function automatic logic signed [ZW-1:0] sat(input logic signed [RES_W-1:0] v);
		logic ovf;
		ovf = (v[RES_W-1:ZW-1] != '0) && (v[RES_W-1:ZW-1] != '1);
		if (!ovf)
			sat = v[ZW-1:0];
		else if (v[RES_W-1])
			sat = {1'b1, {(ZW-1){1'b0}}};
		else
			sat = {1'b0, {(ZW-1){1'b1}}};
	endfunction

	logic               out_valid_q;
	amzmp_pkg::result_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (sum_z_q == '0) begin
				out_data_q.zmp_x        <= com_x_q;
				out_data_q.zmp_y        <= com_y_q;
				out_data_q.zero_divisor <= 1'b1;
			end else begin
				out_data_q.zmp_x        <= sat(res_x);
				out_data_q.zmp_y        <= sat(res_y);
				out_data_q.zero_divisor <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_data_q;
	assign stat.sum_z_zero = (sum_z_q == '0);
	assign stat.out_busy   = out_valid_q && !out_ready;

endmodule

>>> rtl/amzmp_ctrl.sv
module amzmp_ctrl #(
	parameter int DIV_STEPS = 44
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  amzmp_pkg::stat_t stat,
	output amzmp_pkg::cmd_t  cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		IDLE,
		UPD,
		MULX,
		MULY,
		LOAD,
		DIV,
		FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ready_q;
	logic             accept;

	assign accept = (state_q == IDLE) && in_valid && ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= UPD;
						ready_q <= 1'b0;
					end
				end
				UPD:  state_q <= MULX;
				MULX: state_q <= MULY;
				MULY: state_q <= LOAD;
				LOAD: begin
					cnt_q   <= CNT_W'(DIV_STEPS - 1);
					state_q <= stat.sum_z_zero ? FINISH : DIV;
				end
				DIV: begin
					if (cnt_q == '0)
						state_q <= FINISH;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				FINISH: begin
					if (!stat.out_busy) begin
						state_q <= IDLE;
						ready_q <= 1'b1;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.accept   = accept;
		cmd.update   = (state_q == UPD);
		cmd.mul_x    = (state_q == MULX);
		cmd.mul_y    = (state_q == MULY);
		cmd.load     = (state_q == LOAD);
		cmd.div_step = (state_q == DIV);
		cmd.finish   = (state_q == FINISH) && !stat.out_busy;
	end

	assign in_ready = ready_q;

endmodule

>>> rtl/accel_moving_average_zmp.sv
// channel  | dir | payload                            | handshake
// sample   | in  | accel_x, accel_y, accel_z (s16)    | valid/ready
// result   | out | zmp_x, zmp_y (s24), zero_divisor   | valid/ready
// cfg      | in  | cfg_idx 0..2, cfg_data (24b)       | cfg_we, no back-pressure
//
// One sample at a time: a taken request is worked through UPD, MULX, MULY, LOAD, DIV and
// FINISH, with DIV_STEPS = 39 + clog2(WINDOW_LEN) matching the quotient width of the
// one bit per cycle restoring dividers; x and y divide in parallel.
// A zero z-sum skips the divide.
// Reset clears the window valid bits at once, no sweep.
// A stalled result holds in the output register; the next sample is accepted
// while it waits, and its own result waits in FINISH until the register frees.
module accel_moving_average_zmp #(
	parameter int WINDOW_LEN = 30
) (
	input  logic                            clk,
	input  logic                            arst_n,
	amzmp_sample_if.sink                    sample,
	amzmp_result_if.source                  result,
	input  logic                            cfg_we,
	input  logic [amzmp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [amzmp_pkg::CFG_W-1:0]     cfg_data
);

	localparam int DIV_STEPS = amzmp_pkg::COM_W + amzmp_pkg::ACCEL_W
		+ $clog2(WINDOW_LEN) - 1;

	amzmp_pkg::cmd_t  cmd;
	amzmp_pkg::stat_t stat;
	logic             in_ready;

	amzmp_ctrl #(.DIV_STEPS(DIV_STEPS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	amzmp_dp #(.WINDOW_LEN(WINDOW_LEN)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_data   (sample.data),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_data  (result.data)
	);

	assign sample.ready = in_ready;

endmodule

>>> rtl/amzmp_chk.sv
module amzmp_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input amzmp_pkg::result_t out_data
);

	// a held result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// the block stays busy, with in_ready low, after taking a sample
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("sample accepted too soon after previous");

	// a new result only comes out of a sample in flight
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without sample in flight");

endmodule

bind accel_moving_average_zmp amzmp_chk u_amzmp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

>>> bench/accel_moving_average_zmp_tb.sv
module accel_moving_average_zmp_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_LEN = 30;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 28;
	localparam logic [amzmp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic signed [amzmp_pkg::COM_W-1:0] COM_MAX = 24'sh7fffff;
	localparam logic signed [amzmp_pkg::COM_W-1:0] COM_MIN = 24'sh800000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [amzmp_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [amzmp_pkg::CFG_W-1:0] cfg_data;

	amzmp_sample_if sample_ch ();
	amzmp_result_if result_ch ();

	accel_moving_average_zmp #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// shadow of the block: window, sums, slot pointer and registers
	logic signed [amzmp_pkg::ACCEL_W-1:0] win_x [WINDOW_LEN];
	logic signed [amzmp_pkg::ACCEL_W-1:0] win_y [WINDOW_LEN];
	logic signed [amzmp_pkg::ACCEL_W-1:0] win_z [WINDOW_LEN];
	longint win_sum_x;
	longint win_sum_y;
	longint win_sum_z;
	int oldest;
	logic signed [amzmp_pkg::COM_W-1:0] com_x_reg;
	logic signed [amzmp_pkg::COM_W-1:0] com_y_reg;
	logic signed [amzmp_pkg::COM_W-1:0] com_z_reg;

	amzmp_pkg::sample_t pending_samples [$];
	amzmp_pkg::result_t zmp_expected [$];

	int send_idle_pct;
	int recv_stall_pct;
	logic sample_fired;
	int cycles;
	int errors;
	int samples_in;
	int results_out;
	int zero_div_hits;
	int saturated_hits;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic signed [amzmp_pkg::ZMP_W-1:0] clamp24(longint v);
		if (v > longint'(COM_MAX)) begin
			saturated_hits++;
			return COM_MAX;
		end
		if (v < longint'(COM_MIN)) begin
			saturated_hits++;
			return COM_MIN;
		end
		return amzmp_pkg::ZMP_W'(v);
	endfunction

	// shift one sample into the window and solve for the zero moment point
	function automatic amzmp_pkg::result_t zmp_after_sample(amzmp_pkg::sample_t s);
		amzmp_pkg::result_t r;
		longint q_x;
		longint q_y;
		win_sum_x += longint'($signed(s.accel_x)) - longint'(win_x[oldest]);
		win_sum_y += longint'($signed(s.accel_y)) - longint'(win_y[oldest]);
		win_sum_z += longint'($signed(s.accel_z)) - longint'(win_z[oldest]);
		win_x[oldest] = s.accel_x;
		win_y[oldest] = s.accel_y;
		win_z[oldest] = s.accel_z;
		oldest = (oldest == WINDOW_LEN - 1) ? 0 : oldest + 1;
		if (win_sum_z == 0) begin
			r.zmp_x = com_x_reg;
			r.zmp_y = com_y_reg;
			r.zero_divisor = 1'b1;
			zero_div_hits++;
		end else begin
			// signed divide truncates toward zero
			q_x = (longint'(com_z_reg) * win_sum_x) / win_sum_z;
			q_y = (longint'(com_z_reg) * win_sum_y) / win_sum_z;
			r.zmp_x = clamp24(longint'(com_x_reg) - q_x);
			r.zmp_y = clamp24(longint'(com_y_reg) + q_y);
			r.zero_divisor = 1'b0;
		end
		return r;
	endfunction

	function automatic bit roll_pct(int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic logic [amzmp_pkg::ACCEL_W-1:0] pick_extreme();
		case ($urandom_range(4, 0))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'h0001;
			default: return 16'hffff;
		endcase
	endfunction

	function automatic amzmp_pkg::sample_t random_sample();
		amzmp_pkg::sample_t s;
		int kind;
		kind = $urandom_range(99, 0);
		if (kind < 45) begin
			s.accel_x = amzmp_pkg::ACCEL_W'($urandom);
			s.accel_y = amzmp_pkg::ACCEL_W'($urandom);
			s.accel_z = amzmp_pkg::ACCEL_W'($urandom);
		end else if (kind < 70) begin
			// tiny values keep the z-sum near zero
			s.accel_x = amzmp_pkg::ACCEL_W'(int'($urandom_range(8, 0)) - 4);
			s.accel_y = amzmp_pkg::ACCEL_W'(int'($urandom_range(8, 0)) - 4);
			s.accel_z = amzmp_pkg::ACCEL_W'(int'($urandom_range(8, 0)) - 4);
		end else if (kind < 90) begin
			// robot standing: about 1 g on z, either way up
			s.accel_x = amzmp_pkg::ACCEL_W'(int'($urandom_range(1024, 0)) - 512);
			s.accel_y = amzmp_pkg::ACCEL_W'(int'($urandom_range(1024, 0)) - 512);
			s.accel_z = amzmp_pkg::ACCEL_W'(2509 + int'($urandom_range(256, 0)) - 128);
			if ($urandom_range(3, 0) == 0)
				s.accel_z = -s.accel_z;
		end else begin
			s.accel_x = pick_extreme();
			s.accel_y = pick_extreme();
			s.accel_z = pick_extreme();
		end
		return s;
	endfunction

	task automatic push_xyz(int x, int y, int z);
		amzmp_pkg::sample_t s;
		s.accel_x = amzmp_pkg::ACCEL_W'(x);
		s.accel_y = amzmp_pkg::ACCEL_W'(y);
		s.accel_z = amzmp_pkg::ACCEL_W'(z);
		pending_samples.push_back(s);
	endtask

	task automatic write_reg(logic [amzmp_pkg::CFG_IDX_W-1:0] idx,
		logic [amzmp_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_samples.size() != 0 || sample_ch.valid || zmp_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(string field, int got, int want);
		errors++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
	endtask

	initial begin
		for (int i = 0; i < WINDOW_LEN; i++) begin
			win_x[i] = '0;
			win_y[i] = '0;
			win_z[i] = '0;
		end
		win_sum_x = 0;
		win_sum_y = 0;
		win_sum_z = 0;
		oldest = 0;
		com_x_reg = '0;
		com_y_reg = '0;
		com_z_reg = amzmp_pkg::COM_Z_RESET;
	end

	// register shadow follows each write at its edge; index 3 is dropped
	always @(posedge clk) begin
		if (arst_n && cfg_we) begin
			case (cfg_idx)
				amzmp_pkg::CFG_COM_X: com_x_reg = cfg_data;
				amzmp_pkg::CFG_COM_Y: com_y_reg = cfg_data;
				amzmp_pkg::CFG_COM_Z: com_z_reg = cfg_data;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// request side
	always @(posedge clk) begin
		sample_fired <= arst_n && sample_ch.valid && sample_ch.ready;
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			zmp_expected.push_back(zmp_after_sample(sample_ch.data));
			samples_in++;
		end
	end

	always @(negedge clk) begin
		if (!sample_ch.valid || sample_fired) begin
			if (arst_n && pending_samples.size() != 0 && !roll_pct(send_idle_pct)) begin
				sample_ch.data <= pending_samples.pop_front();
				sample_ch.valid <= 1'b1;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// result side
	always @(negedge clk) begin
		result_ch.ready <= arst_n && !roll_pct(recv_stall_pct);
	end

	always @(posedge clk) begin
		amzmp_pkg::result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_out++;
			if (zmp_expected.size() == 0) begin
				errors++;
				$display("[%0t] result with nothing outstanding", $time);
			end else begin
				want = zmp_expected.pop_front();
				if (result_ch.data.zmp_x !== want.zmp_x)
					report_mismatch("zmp_x", int'($signed(result_ch.data.zmp_x)),
						int'(want.zmp_x));
				if (result_ch.data.zmp_y !== want.zmp_y)
					report_mismatch("zmp_y", int'($signed(result_ch.data.zmp_y)),
						int'(want.zmp_y));
				if (result_ch.data.zero_divisor !== want.zero_divisor)
					report_mismatch("zero_divisor", int'(result_ch.data.zero_divisor),
						int'(want.zero_divisor));
			end
		end
	end

	initial begin
		int burst_at;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		result_ch.ready = 1'b0;
		sample_fired = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cycles = 0;
		errors = 0;
		samples_in = 0;
		results_out = 0;
		zero_div_hits = 0;
		saturated_hits = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty window, extremes, z-sum returning to zero, saturation
		push_xyz(0, 0, 0);
		push_xyz(32767, 32767, 32767);
		push_xyz(-32768, -32768, -32768);
		push_xyz(1, -1, 1);
		push_xyz(32767, -32768, 1);
		push_xyz(-32768, 32767, -1);
		push_xyz(-32768, 32767, -2);
		push_xyz(32767, -32768, 3);
		push_xyz(3, -5, 7);
		push_xyz(-7, 5, -3);
		push_xyz(0, 0, -5);
		push_xyz(1, 1, 1);
		push_xyz(-1, -1, -1);
		push_xyz(2509, -300, 2509);
		push_xyz(-2509, 300, -2510);
		push_xyz(0, 0, 32767);
		push_xyz(0, 0, -32768);
		push_xyz(-1, 32767, 0);
		push_xyz(32767, 0, 1);
		push_xyz(-32768, -32768, 0);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					write_reg(amzmp_pkg::CFG_COM_X, '0);
					write_reg(amzmp_pkg::CFG_COM_Y, '0);
					write_reg(amzmp_pkg::CFG_COM_Z, amzmp_pkg::COM_Z_RESET);
					write_reg(CFG_UNUSED, amzmp_pkg::CFG_W'($urandom));
				end
				1: begin
					write_reg(amzmp_pkg::CFG_COM_X, COM_MAX);
					write_reg(amzmp_pkg::CFG_COM_Y, COM_MIN);
					write_reg(amzmp_pkg::CFG_COM_Z, COM_MAX);
				end
				2: begin
					write_reg(amzmp_pkg::CFG_COM_X, COM_MIN);
					write_reg(amzmp_pkg::CFG_COM_Y, COM_MAX);
					write_reg(amzmp_pkg::CFG_COM_Z, COM_MIN);
				end
				3: begin
					write_reg(amzmp_pkg::CFG_COM_X, amzmp_pkg::CFG_W'($urandom));
					write_reg(amzmp_pkg::CFG_COM_Y, amzmp_pkg::CFG_W'($urandom));
					write_reg(amzmp_pkg::CFG_COM_Z, amzmp_pkg::CFG_W'($urandom));
				end
				4: begin
					write_reg(amzmp_pkg::CFG_COM_X, '0);
					write_reg(amzmp_pkg::CFG_COM_Y, '0);
					write_reg(amzmp_pkg::CFG_COM_Z, '0);
				end
				5: begin
					write_reg(amzmp_pkg::CFG_COM_X,
						amzmp_pkg::CFG_W'(int'($urandom_range(8192, 0)) - 4096));
					write_reg(amzmp_pkg::CFG_COM_Y,
						amzmp_pkg::CFG_W'(int'($urandom_range(8192, 0)) - 4096));
					write_reg(amzmp_pkg::CFG_COM_Z, amzmp_pkg::CFG_W'(1));
				end
				6: begin
					write_reg(amzmp_pkg::CFG_COM_X, amzmp_pkg::CFG_W'($urandom));
					write_reg(amzmp_pkg::CFG_COM_Y, amzmp_pkg::CFG_W'($urandom));
					write_reg(amzmp_pkg::CFG_COM_Z, '1);
				end
				default: begin
					write_reg(amzmp_pkg::CFG_COM_X,
						amzmp_pkg::CFG_W'(int'($urandom_range(2560, 0)) - 1280));
					write_reg(amzmp_pkg::CFG_COM_Y,
						amzmp_pkg::CFG_W'(int'($urandom_range(2560, 0)) - 1280));
					write_reg(amzmp_pkg::CFG_COM_Z, amzmp_pkg::COM_Z_RESET);
				end
			endcase
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 86; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 86; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			// a run of flat z fills the window with zeros: z-sum hits zero
			burst_at = $urandom_range(ITEMS_PER_PHASE - 1, 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i == burst_at) begin
					repeat (WINDOW_LEN + $urandom_range(4, 0))
						push_xyz(int'($urandom_range(65535, 0)) - 32768,
							int'($urandom_range(65535, 0)) - 32768, 0);
				end
				pending_samples.push_back(random_sample());
			end
			wait_drained();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d samples sent over %0d register settings, %0d results checked",
			samples_in, PHASES + 1, results_out);
		$display("%0d results with a zero z-sum, %0d saturated coordinates",
			zero_div_hits, saturated_hits);
		if (errors == 0 && zmp_expected.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, zmp_expected.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/amzmp_pkg.sv
rtl/amzmp_if.sv
rtl/amzmp_div.sv
rtl/amzmp_dp.sv
rtl/amzmp_ctrl.sv
rtl/accel_moving_average_zmp.sv
rtl/amzmp_chk.sv
bench/accel_moving_average_zmp_tb.sv
